FILE: rtl/lwf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwf_pkg
// Shared types, codes and constants for the LCD window fill sequencer.
// ----------------------------------------------------------------------------
package lwf_pkg;

    localparam int PANEL_WIDTH  = 320;
    localparam int PANEL_HEIGHT = 480;

    localparam int COORD_W = 9;
    localparam int STEP_W  = 4;

    // step at which the pixel stream starts
    localparam logic [STEP_W-1:0] STEP_PIXELS = 4'd11;

    localparam logic [7:0] CMD_COL_SET   = 8'h2A;
    localparam logic [7:0] CMD_ROW_SET   = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;
    localparam logic [7:0] CMD_MADCTL    = 8'h36;
    localparam logic [7:0] CMD_INV_ON    = 8'h21;
    localparam logic [7:0] CMD_INV_OFF   = 8'h20;

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_FILL = 2'd1,
        REQ_ROT  = 2'd2,
        REQ_INV  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_FILL = 2'd1,
        KIND_ROT  = 2'd2,
        KIND_INV  = 2'd3
    } t_kind;

    // clipped fill window
    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] bottom;
    } t_win;

    function automatic logic [7:0] rot_arg(input logic [1:0] rot);
        logic [7:0] b;
        case (rot)
            2'd0:    b = 8'h48;
            2'd1:    b = 8'h28;
            2'd2:    b = 8'h88;
            default: b = 8'hE8;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/lcd_window_fill_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_window_fill_sequencer
// Turns fill, rotation and inversion requests into 8080-style LCD bus bytes.
// ----------------------------------------------------------------------------
// One request or tick transaction is taken per cycle unless a byte waits
// undrained in the output register. A tick while a sequence is running
// yields one bus byte, ready in the output register on the next cycle; the
// input stays open while that byte waits, as long as the output is being
// drained, so bytes go out one per cycle. Fill windows are clipped to the
// panel (sized by the current rotation) as the request is taken; empty
// windows are dropped, and requests arriving mid-sequence are ignored.
module lcd_window_fill_sequencer import lwf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // rect_x[15:0], rect_y[31:16], rect_w[47:32], rect_h[63:48],
    // fill_color[79:64], rotation_sel[81:80], invert_on[82], zero pad[87:83]
    input  logic [87:0] i_s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // bus_byte[7:0]
    output logic [7:0]  o_m_axis_tdata,
    // is_data[0]
    output logic        o_m_axis_tuser,
    output logic        o_m_axis_tlast
);

    t_win       win;
    logic [1:0] rotation;
    logic       accept;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    lwf_clip u_clip (
        .i_rotation (rotation),
        .i_rect_x   (i_s_axis_tdata[15:0]),
        .i_rect_y   (i_s_axis_tdata[31:16]),
        .i_rect_w   (i_s_axis_tdata[47:32]),
        .i_rect_h   (i_s_axis_tdata[63:48]),
        .o_win      (win)
    );

    lwf_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_req          (t_req'(i_s_axis_tuser)),
        .i_win          (win),
        .i_color        (i_s_axis_tdata[79:64]),
        .i_rotation_sel (i_s_axis_tdata[81:80]),
        .i_invert_on    (i_s_axis_tdata[82]),
        .i_out_ready    (i_m_axis_tready),
        .o_in_ready     (o_s_axis_tready),
        .o_rotation     (rotation),
        .o_out_valid    (o_m_axis_tvalid),
        .o_bus_byte     (o_m_axis_tdata),
        .o_is_data      (o_m_axis_tuser),
        .o_last_byte    (o_m_axis_tlast)
    );

endmodule

FILE: rtl/lwf_clip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwf_clip
// Clips a signed fill rectangle to the panel for the current rotation.
// ----------------------------------------------------------------------------
module lwf_clip import lwf_pkg::*; (
    input  logic [1:0]  i_rotation,
    input  logic [15:0] i_rect_x,
    input  logic [15:0] i_rect_y,
    input  logic [15:0] i_rect_w,
    input  logic [15:0] i_rect_h,
    output t_win        o_win
);

    logic signed [17:0] x, y, w, h, pw, ph, xe, ye, re, be;

    always_comb begin
        pw = i_rotation[0] ? 18'(PANEL_HEIGHT) : 18'(PANEL_WIDTH);
        ph = i_rotation[0] ? 18'(PANEL_WIDTH)  : 18'(PANEL_HEIGHT);
        x  = 18'(signed'(i_rect_x));
        y  = 18'(signed'(i_rect_y));
        w  = 18'(signed'(i_rect_w));
        h  = 18'(signed'(i_rect_h));
        // exclusive far edges, cut at the panel
        xe = x + w;
        ye = y + h;
        re = (xe > pw) ? pw : xe;
        be = (ye > ph) ? ph : ye;
        re = re - 18'sd1;
        be = be - 18'sd1;

        // a far edge at or left of zero means the window vanished after clipping
        o_win.valid  = (x < pw) && (y < ph) && (w > 18'sd0) && (h > 18'sd0)
                       && (xe > 18'sd0) && (ye > 18'sd0);
        o_win.left   = (x < 18'sd0) ? '0 : x[COORD_W-1:0];
        o_win.top    = (y < 18'sd0) ? '0 : y[COORD_W-1:0];
        o_win.right  = re[COORD_W-1:0];
        o_win.bottom = be[COORD_W-1:0];
    end

endmodule

FILE: rtl/lwf_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwf_seq
// Request decode, byte sequencer and output register.
// ----------------------------------------------------------------------------
module lwf_seq import lwf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  t_req               i_req,
    input  t_win               i_win,
    input  logic [15:0]        i_color,
    input  logic [1:0]         i_rotation_sel,
    input  logic               i_invert_on,
    input  logic               i_out_ready,
    output logic               o_in_ready,
    output logic [1:0]         o_rotation,
    output logic               o_out_valid,
    output logic [7:0]         o_bus_byte,
    output logic               o_is_data,
    output logic               o_last_byte
);

    logic               r_busy, n_busy;
    t_kind              r_kind, n_kind;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [COORD_W-1:0] r_left, n_left, r_right, n_right;
    logic [COORD_W-1:0] r_top, n_top, r_bottom, n_bottom;
    logic [COORD_W-1:0] r_col, n_col, r_row, n_row;
    logic [15:0]        r_color, n_color;
    logic               r_low_half, n_low_half;
    logic [1:0]         r_rotation, n_rotation;
    logic [7:0]         r_arg, n_arg;

    logic               r_out_valid, n_out_valid;
    logic [7:0]         r_byte, n_byte;
    logic               r_is_data, n_is_data;
    logic               r_last, n_last;

    logic               emit;
    logic [7:0]         e_byte;
    logic               e_data, e_last;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_rotation  = r_rotation;
    assign o_out_valid = r_out_valid;
    assign o_bus_byte  = r_byte;
    assign o_is_data   = r_is_data;
    assign o_last_byte = r_last;

    always_comb begin
        n_busy      = r_busy;
        n_kind      = r_kind;
        n_step      = r_step;
        n_left      = r_left;
        n_right     = r_right;
        n_top       = r_top;
        n_bottom    = r_bottom;
        n_col       = r_col;
        n_row       = r_row;
        n_color     = r_color;
        n_low_half  = r_low_half;
        n_rotation  = r_rotation;
        n_arg       = r_arg;
        emit        = 1'b0;
        e_byte      = '0;
        e_data      = 1'b0;
        e_last      = 1'b0;

        if (i_accept) begin
            case (i_req)
                REQ_TICK: begin
                    if (r_busy) begin
                        emit = 1'b1;
                        case (r_kind)
                            KIND_FILL: begin
                                if (r_step >= STEP_PIXELS) begin
                                    e_data = 1'b1;
                                    if (!r_low_half) begin
                                        n_low_half = 1'b1;
                                        e_byte     = r_color[15:8];
                                    end else begin
                                        n_low_half = 1'b0;
                                        e_byte     = r_color[7:0];
                                        // raster walk over the window stands in for a pixel count
                                        if (r_col == r_right) begin
                                            n_col = r_left;
                                            if (r_row == r_bottom) begin
                                                e_last = 1'b1;
                                            end else begin
                                                n_row = r_row + 1'b1;
                                            end
                                        end else begin
                                            n_col = r_col + 1'b1;
                                        end
                                    end
                                end else begin
                                    n_step = r_step + 1'b1;
                                    e_data = 1'b1;
                                    case (r_step)
                                        4'd0: begin
                                            e_byte = CMD_COL_SET;
                                            e_data = 1'b0;
                                        end
                                        4'd1: e_byte = {7'd0, r_left[8]};
                                        4'd2: e_byte = r_left[7:0];
                                        4'd3: e_byte = {7'd0, r_right[8]};
                                        4'd4: e_byte = r_right[7:0];
                                        4'd5: begin
                                            e_byte = CMD_ROW_SET;
                                            e_data = 1'b0;
                                        end
                                        4'd6: e_byte = {7'd0, r_top[8]};
                                        4'd7: e_byte = r_top[7:0];
                                        4'd8: e_byte = {7'd0, r_bottom[8]};
                                        4'd9: e_byte = r_bottom[7:0];
                                        default: begin
                                            e_byte = CMD_MEM_WRITE;
                                            e_data = 1'b0;
                                        end
                                    endcase
                                end
                            end
                            KIND_ROT: begin
                                if (r_step == '0) begin
                                    n_step = 4'd1;
                                    e_byte = CMD_MADCTL;
                                end else begin
                                    e_byte = r_arg;
                                    e_data = 1'b1;
                                    e_last = 1'b1;
                                end
                            end
                            default: begin
                                e_byte = r_arg;
                                e_last = 1'b1;
                            end
                        endcase
                        if (e_last) begin
                            n_busy = 1'b0;
                        end
                    end
                end
                REQ_FILL: begin
                    if (!r_busy && i_win.valid) begin
                        n_left     = i_win.left;
                        n_right    = i_win.right;
                        n_top      = i_win.top;
                        n_bottom   = i_win.bottom;
                        n_col      = i_win.left;
                        n_row      = i_win.top;
                        n_color    = i_color;
                        n_low_half = 1'b0;
                        n_kind     = KIND_FILL;
                        n_step     = '0;
                        n_busy     = 1'b1;
                    end
                end
                REQ_ROT: begin
                    if (!r_busy) begin
                        n_rotation = i_rotation_sel;
                        n_arg      = rot_arg(i_rotation_sel);
                        n_kind     = KIND_ROT;
                        n_step     = '0;
                        n_busy     = 1'b1;
                    end
                end
                default: begin
                    if (!r_busy) begin
                        n_arg  = i_invert_on ? CMD_INV_ON : CMD_INV_OFF;
                        n_kind = KIND_INV;
                        n_step = '0;
                        n_busy = 1'b1;
                    end
                end
            endcase
        end
    end

    // output register: loads on an emitting tick, empties when taken
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_byte      = r_byte;
        n_is_data   = r_is_data;
        n_last      = r_last;
        if (emit) begin
            n_out_valid = 1'b1;
            n_byte      = e_byte;
            n_is_data   = e_data;
            n_last      = e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_kind      <= KIND_NONE;
            r_step      <= '0;
            r_left      <= '0;
            r_right     <= '0;
            r_top       <= '0;
            r_bottom    <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_color     <= '0;
            r_low_half  <= 1'b0;
            r_rotation  <= '0;
            r_arg       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_kind      <= n_kind;
            r_step      <= n_step;
            r_left      <= n_left;
            r_right     <= n_right;
            r_top       <= n_top;
            r_bottom    <= n_bottom;
            r_col       <= n_col;
            r_row       <= n_row;
            r_color     <= n_color;
            r_low_half  <= n_low_half;
            r_rotation  <= n_rotation;
            r_arg       <= n_arg;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte    <= n_byte;
        r_is_data <= n_is_data;
        r_last    <= n_last;
    end

endmodule
